// ===== hw/rtl/mps_pkg.sv =====
// ---------------------------------------------------------------------------
// mps_pkg
// Shared types, codes and helper functions for the motion program sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

  localparam int NumSteps = 3;

  localparam logic [15:0] StatusMask   = 16'h006F;
  localparam logic [15:0] StatusOpEn   = 16'h0027;
  localparam logic signed [32:0] StepTol   = 33'sd100;
  localparam logic signed [32:0] ReturnTol = 33'sd5;
  localparam logic [6:0]  TorqueMax    = 7'd100;
  localparam logic [31:0] ReturnSpeedRst = 32'd100;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  localparam logic [1:0] TW_NONE = 2'd0;
  localparam logic [1:0] TW_USER = 2'd1;
  localparam logic [1:0] TW_HW   = 2'd2;

  localparam logic [2:0] REG_STEP1_POS   = 3'd0;
  localparam logic [2:0] REG_STEP2_POS   = 3'd1;
  localparam logic [2:0] REG_STEP3_POS   = 3'd2;
  localparam logic [2:0] REG_STEP1_ST    = 3'd3;
  localparam logic [2:0] REG_STEP2_ST    = 3'd4;
  localparam logic [2:0] REG_STEP3_ST    = 3'd5;
  localparam logic [2:0] REG_DWELL       = 3'd6;
  localparam logic [2:0] REG_RETURN_SPD  = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_STEP1  = 3'd1,
    PH_STEP2  = 3'd2,
    PH_STEP3  = 3'd3,
    PH_DWELL  = 3'd4,
    PH_RETURN = 3'd5
  } phase_t;

  typedef struct packed {
    logic [NumSteps-1:0][31:0] step_pos;
    logic [NumSteps-1:0][47:0] step_st;
    logic [31:0]               dwell_ms;
    logic [31:0]               return_speed;
  } mps_cfg_t;

  typedef struct packed {
    logic               start_accepted;
    logic [1:0]         target_write;
    logic signed [31:0] target_value;
    logic               profile_write;
    logic [30:0]        profile_speed;
    logic [6:0]         torque_limit;
    logic [2:0]         sequence_state;
  } mps_result_t;

  function automatic logic [30:0] speed_of(input logic [31:0] v);
    logic [31:0] mag;
    logic [30:0] s;
    mag = v[31] ? (32'd0 - v) : v;
    if (mag[31]) begin
      s = 31'h7FFF_FFFF;
    end else begin
      s = mag[30:0];
    end
    if (s == 31'd0) begin
      s = 31'd1;
    end
    return s;
  endfunction

  function automatic logic [6:0] torque_of(input logic [15:0] v);
    logic [16:0] ext;
    logic [16:0] mag;
    logic [6:0]  t;
    ext = {v[15], v};
    mag = v[15] ? (17'd0 - ext) : ext;
    if (mag > {10'd0, TorqueMax}) begin
      t = TorqueMax;
    end else if (mag == 17'd0) begin
      t = 7'd1;
    end else begin
      t = mag[6:0];
    end
    return t;
  endfunction

  function automatic logic near(input logic [31:0] a, input logic [31:0] b,
                                input logic signed [32:0] tol);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return (d <= tol) && (d >= -tol);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mps_cfg.sv =====
// ---------------------------------------------------------------------------
// mps_cfg
// Configuration register file: step program, dwell and return speed.
// ---------------------------------------------------------------------------
`default_nettype none

module mps_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [2:0]        wr_index,
  input  wire logic [47:0]       wr_data,
  output mps_pkg::mps_cfg_t      cfg
);
  import mps_pkg::*;

  mps_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.step_pos     <= '0;
      regs.step_st      <= '0;
      regs.dwell_ms     <= '0;
      regs.return_speed <= ReturnSpeedRst;
    end else if (wr_en) begin
      case (wr_index)
        REG_STEP1_POS:  regs.step_pos[0]    <= wr_data[31:0];
        REG_STEP2_POS:  regs.step_pos[1]    <= wr_data[31:0];
        REG_STEP3_POS:  regs.step_pos[2]    <= wr_data[31:0];
        REG_STEP1_ST:   regs.step_st[0]     <= wr_data;
        REG_STEP2_ST:   regs.step_st[1]     <= wr_data;
        REG_STEP3_ST:   regs.step_st[2]     <= wr_data;
        REG_DWELL:      regs.dwell_ms       <= wr_data[31:0];
        REG_RETURN_SPD: regs.return_speed   <= wr_data[31:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== hw/rtl/mps_core.sv =====
// ---------------------------------------------------------------------------
// mps_core
// Sequencer state and the single-pass decision logic for one word.
// ---------------------------------------------------------------------------
`default_nettype none

module mps_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire mps_pkg::mps_cfg_t  cfg,
  input  wire logic [1:0]         mode,
  input  wire logic               pdo_ready,
  input  wire logic               run_enabled,
  input  wire logic [15:0]        status_word,
  input  wire logic [31:0]        actual_position,
  input  wire logic [31:0]        actual_position_hw,
  input  wire logic [31:0]        now_ms,
  output mps_pkg::mps_result_t    result
);
  import mps_pkg::*;

  phase_t phase;
  phase_t phase_next;

  logic [NumSteps-1:0][31:0] latched_positions;
  logic [NumSteps-1:0][30:0] latched_speeds;
  logic [NumSteps-1:0][6:0]  latched_torques;
  logic [31:0] latched_dwell;
  logic [31:0] origin_user;
  logic [31:0] origin_hw;
  logic [31:0] active_target;
  logic [31:0] dwell_start_ms;

  logic start_ok;
  logic stop_ok;
  logic tick;
  logic near_step;
  logic near_home;
  logic dwell_done;
  logic load_step;
  logic enter_dwell;
  logic enter_return;
  logic finish;
  logic [1:0]  step_idx;
  logic [31:0] step_pos;
  logic [30:0] step_speed;
  logic [6:0]  step_torque;
  logic [31:0] elapsed;

  assign start_ok = accept && (mode == MODE_START) && (phase == PH_IDLE) && pdo_ready &&
                    run_enabled && ((status_word & StatusMask) == StatusOpEn);
  assign stop_ok  = accept && (mode == MODE_STOP) && (phase != PH_IDLE);
  assign tick     = accept && (mode == MODE_TICK) && pdo_ready;

  assign near_step  = near(actual_position, active_target, StepTol);
  assign near_home  = near(actual_position_hw, origin_hw, ReturnTol);
  assign elapsed    = now_ms - dwell_start_ms;
  assign dwell_done = (elapsed >= latched_dwell);

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (start_ok) phase_next = PH_STEP1;
      end
      PH_STEP1: begin
        if (stop_ok) phase_next = PH_IDLE;
        else if (tick && near_step) phase_next = PH_STEP2;
      end
      PH_STEP2: begin
        if (stop_ok) phase_next = PH_IDLE;
        else if (tick && near_step) phase_next = PH_STEP3;
      end
      PH_STEP3: begin
        if (stop_ok) phase_next = PH_IDLE;
        else if (tick && near_step) phase_next = PH_DWELL;
      end
      PH_DWELL: begin
        if (stop_ok) phase_next = PH_IDLE;
        else if (tick && dwell_done) phase_next = PH_RETURN;
      end
      PH_RETURN: begin
        if (stop_ok) phase_next = PH_IDLE;
        else if (tick && near_home) phase_next = PH_IDLE;
      end
      default: begin
        if (stop_ok) phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    load_step    = (phase_next != phase) &&
                   (phase_next == PH_STEP1 || phase_next == PH_STEP2 ||
                    phase_next == PH_STEP3);
    enter_dwell  = (phase == PH_STEP3) && (phase_next == PH_DWELL);
    enter_return = (phase == PH_DWELL) && (phase_next == PH_RETURN);
    finish       = (phase == PH_RETURN) && (phase_next == PH_IDLE) && !stop_ok;
    step_idx     = 2'(phase_next - PH_STEP1);

    if (start_ok) begin
      step_pos    = cfg.step_pos[0];
      step_speed  = speed_of(cfg.step_st[0][31:0]);
      step_torque = torque_of(cfg.step_st[0][47:32]);
    end else begin
      step_pos    = latched_positions[step_idx];
      step_speed  = latched_speeds[step_idx];
      step_torque = latched_torques[step_idx];
    end

    result                = '0;
    result.start_accepted = start_ok;
    result.sequence_state = phase_next;
    if (load_step) begin
      result.profile_write = 1'b1;
      result.profile_speed = step_speed;
      result.torque_limit  = step_torque;
      result.target_write  = TW_USER;
      result.target_value  = step_pos;
    end else if (enter_return) begin
      result.profile_write = 1'b1;
      result.profile_speed = speed_of(cfg.return_speed);
      result.torque_limit  = latched_torques[NumSteps-1];
      result.target_write  = TW_HW;
      result.target_value  = origin_hw;
    end else if (stop_ok) begin
      result.target_write  = TW_USER;
      result.target_value  = actual_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumSteps; i++) begin
        latched_positions[i] <= '0;
        latched_speeds[i]    <= 31'd1;
        latched_torques[i]   <= 7'd1;
      end
      latched_dwell  <= '0;
      origin_user    <= '0;
      origin_hw      <= '0;
      active_target  <= '0;
      dwell_start_ms <= '0;
    end else begin
      if (start_ok) begin
        for (int i = 0; i < NumSteps; i++) begin
          latched_positions[i] <= cfg.step_pos[i];
          latched_speeds[i]    <= speed_of(cfg.step_st[i][31:0]);
          latched_torques[i]   <= torque_of(cfg.step_st[i][47:32]);
        end
        latched_dwell <= cfg.dwell_ms[31] ? 32'd0 : cfg.dwell_ms;
        origin_user   <= actual_position;
        origin_hw     <= actual_position_hw;
      end
      if (load_step) begin
        active_target <= step_pos;
      end else if (enter_return) begin
        active_target <= origin_user;
      end
      if (enter_dwell) begin
        dwell_start_ms <= now_ms;
      end else if (start_ok || stop_ok || finish) begin
        dwell_start_ms <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mps_obuf.sv =====
// ---------------------------------------------------------------------------
// mps_obuf
// Two-entry result buffer: output register plus skid register.
// ---------------------------------------------------------------------------
`default_nettype none

module mps_obuf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire mps_pkg::mps_result_t push_data,
  output logic                      full,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output mps_pkg::mps_result_t      out_data
);
  import mps_pkg::*;

  mps_result_t head;
  mps_result_t skid;
  logic        head_valid;
  logic        skid_valid;
  logic        take;

  assign take = head_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!head_valid || take) begin
        head_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      head_valid <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!head_valid || take) begin
        head <= push_data;
      end else begin
        skid <= push_data;
      end
    end else if (take && skid_valid) begin
      head <= skid;
    end
  end

  assign full      = skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

endmodule

`default_nettype wire

// ===== hw/rtl/motion_program_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// motion_program_sequencer_unit
// Three-step servo motion program with dwell and return to origin.
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  in        in_valid / in_stall  mode .. now_ms
//  out       out_valid / out_stall start_accepted .. sequence_state
//  cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One word per cycle while in_stall is low; its result is registered.
//  Sequencer state updates in the cycle the word is taken.
//  rst is synchronous; it idles the sequencer and loads register defaults.
//  in_stall rises only when a result is held and a second one is parked.
// ---------------------------------------------------------------------------
`default_nettype none

module motion_program_sequencer_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic               pdo_ready,
  input  wire logic               run_enabled,
  input  wire logic [15:0]        status_word,
  input  wire logic signed [31:0] actual_position,
  input  wire logic signed [31:0] actual_position_hw,
  input  wire logic [31:0]        now_ms,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    start_accepted,
  output logic [1:0]              target_write,
  output logic signed [31:0]      target_value,
  output logic                    profile_write,
  output logic [30:0]             profile_speed,
  output logic [6:0]              torque_limit,
  output logic [2:0]              sequence_state,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [47:0]        cfg_data
);
  import mps_pkg::*;

  mps_cfg_t    cfg;
  mps_result_t result;
  mps_result_t out_data;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  mps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mps_core u_core (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .cfg                (cfg),
    .mode               (mode),
    .pdo_ready          (pdo_ready),
    .run_enabled        (run_enabled),
    .status_word        (status_word),
    .actual_position    (actual_position),
    .actual_position_hw (actual_position_hw),
    .now_ms             (now_ms),
    .result             (result)
  );

  mps_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign start_accepted = out_data.start_accepted;
  assign target_write   = out_data.target_write;
  assign target_value   = out_data.target_value;
  assign profile_write  = out_data.profile_write;
  assign profile_speed  = out_data.profile_speed;
  assign torque_limit   = out_data.torque_limit;
  assign sequence_state = out_data.sequence_state;

endmodule

`default_nettype wire

// ===== hw/rtl/mps_checker.sv =====
// ---------------------------------------------------------------------------
// mps_checker
// Port-level checks for the motion program sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module mps_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               start_accepted,
  input wire logic [1:0]         target_write,
  input wire logic signed [31:0] target_value,
  input wire logic               profile_write,
  input wire logic [30:0]        profile_speed,
  input wire logic [6:0]         torque_limit,
  input wire logic [2:0]         sequence_state
);
  import mps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(target_value) &&
      $stable(sequence_state) && $stable(target_write))
    else $error("result word changed while stalled");

  a_start_step1: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_accepted |->
      sequence_state == PH_STEP1 && profile_write && target_write == TW_USER)
    else $error("accepted start did not command step one");

  a_return_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && target_write == TW_HW |->
      sequence_state == PH_RETURN && profile_write)
    else $error("hardware target outside return move");

  a_profile_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && profile_write |->
      profile_speed != 31'd0 && torque_limit != 7'd0 && torque_limit <= TorqueMax)
    else $error("profile out of range");

  a_no_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && target_write == TW_NONE |-> target_value == 32'sd0)
    else $error("target value without target command");

endmodule

bind motion_program_sequencer_unit mps_checker u_mps_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .start_accepted (start_accepted),
  .target_write   (target_write),
  .target_value   (target_value),
  .profile_write  (profile_write),
  .profile_speed  (profile_speed),
  .torque_limit   (torque_limit),
  .sequence_state (sequence_state)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives tick, start and stop words into the motion program sequencer and
// checks every command word it returns against a cycle-free model of the
// three-step program, dwell and return-to-origin sequence. Directed words
// cover rejects, reset defaults, saturation and dwell wrap; random programs
// follow, with random gaps on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import mps_pkg::*;

  localparam int ClkHalf       = 5;
  localparam int ResetCycles   = 7;
  localparam int SettleCycles  = 4;
  localparam int QuietLimit    = 1000;
  localparam int RandPhases    = 8;
  localparam int WordsPerPhase = 90;
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic               pdo;
    logic               run;
    logic [15:0]        status;
    logic signed [31:0] pos;
    logic signed [31:0] pos_hw;
    logic [31:0]        now;
  } cmd_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][47:0] st;
    logic [31:0]      dwell;
    logic [31:0]      ret;
  } prog_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = MODE_TICK;
  logic               pdo_ready = 1'b0;
  logic               run_enabled = 1'b0;
  logic [15:0]        status_word = '0;
  logic signed [31:0] actual_position = '0;
  logic signed [31:0] actual_position_hw = '0;
  logic [31:0]        now_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               start_accepted;
  logic [1:0]         target_write;
  logic signed [31:0] target_value;
  logic               profile_write;
  logic [30:0]        profile_speed;
  logic [6:0]         torque_limit;
  logic [2:0]         sequence_state;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [47:0]        cfg_data = '0;

  // register shadow
  logic [31:0] cfg_pos [3];
  logic [47:0] cfg_st [3];
  logic [31:0] cfg_dwell;
  logic [31:0] cfg_ret;

  // sequencer model state
  phase_t             seq_phase;
  logic signed [31:0] lat_pos [3];
  logic [30:0]        lat_speed [3];
  logic [6:0]         lat_torque [3];
  logic [31:0]        lat_dwell;
  logic signed [31:0] org_user;
  logic signed [31:0] org_hw;
  logic signed [31:0] act_target;
  logic [31:0]        dwell_t0;

  mps_result_t due_results [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;
  logic [31:0] ms_now;

  motion_program_sequencer_unit u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .mode               (mode),
    .pdo_ready          (pdo_ready),
    .run_enabled        (run_enabled),
    .status_word        (status_word),
    .actual_position    (actual_position),
    .actual_position_hw (actual_position_hw),
    .now_ms             (now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .start_accepted     (start_accepted),
    .target_write       (target_write),
    .target_value       (target_value),
    .profile_write      (profile_write),
    .profile_speed      (profile_speed),
    .torque_limit       (torque_limit),
    .sequence_state     (sequence_state),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #ClkHalf clk = ~clk;

  function automatic longint abs_clip(longint v);
    if (v < 0) begin
      v = -v;
    end
    if (v > 64'sh7FFF_FFFF) begin
      v = 64'sh7FFF_FFFF;
    end
    return v;
  endfunction

  function automatic logic [30:0] speed_limit(logic [31:0] raw);
    longint v;
    v = abs_clip(longint'($signed(raw)));
    if (v < 1) begin
      v = 1;
    end
    return v[30:0];
  endfunction

  function automatic logic [6:0] torque_clamp(logic [15:0] raw);
    longint v;
    v = abs_clip(longint'($signed(raw)));
    if (v < 1) begin
      v = 1;
    end
    if (v > longint'(TorqueMax)) begin
      v = longint'(TorqueMax);
    end
    return v[6:0];
  endfunction

  function automatic bit within_tol(logic signed [31:0] a, logic signed [31:0] b,
                                    longint tol);
    longint d;
    d = longint'(a) - longint'(b);
    return (d <= tol) && (d >= -tol);
  endfunction

  task automatic reset_model();
    int i;
    for (i = 0; i < NumSteps; i++) begin
      cfg_pos[i] = '0;
      cfg_st[i] = '0;
      lat_pos[i] = '0;
      lat_speed[i] = 31'd1;
      lat_torque[i] = 7'd1;
    end
    cfg_dwell = '0;
    cfg_ret = ReturnSpeedRst;
    seq_phase = PH_IDLE;
    lat_dwell = '0;
    org_user = '0;
    org_hw = '0;
    act_target = '0;
    dwell_t0 = '0;
    ms_now = $urandom;
  endtask

  // work out the command word for one accepted input word
  task automatic advance_sequencer(input cmd_t w);
    mps_result_t r;
    int          nxt;
    int          i;
    logic [31:0] elapsed;
    r = '0;
    nxt = -1;
    case (w.mode)
      MODE_START: begin
        if (seq_phase == PH_IDLE && w.pdo && w.run &&
            (w.status & StatusMask) == StatusOpEn) begin
          for (i = 0; i < NumSteps; i++) begin
            lat_pos[i] = cfg_pos[i];
            lat_speed[i] = speed_limit(cfg_st[i][31:0]);
            lat_torque[i] = torque_clamp(cfg_st[i][47:32]);
          end
          lat_dwell = ($signed(cfg_dwell) > 0) ? cfg_dwell : '0;
          org_user = w.pos;
          org_hw = w.pos_hw;
          dwell_t0 = '0;
          r.start_accepted = 1'b1;
          nxt = 0;
        end
      end
      MODE_STOP: begin
        if (seq_phase != PH_IDLE) begin
          r.target_write = TW_USER;
          r.target_value = w.pos;
          seq_phase = PH_IDLE;
          dwell_t0 = '0;
        end
      end
      MODE_TICK: begin
        if (w.pdo) begin
          case (seq_phase)
            PH_STEP1, PH_STEP2, PH_STEP3: begin
              if (within_tol(w.pos, act_target, StepTol)) begin
                if (seq_phase != PH_STEP3) begin
                  nxt = int'(seq_phase);
                end else begin
                  dwell_t0 = w.now;
                  seq_phase = PH_DWELL;
                end
              end
            end
            PH_DWELL: begin
              elapsed = w.now - dwell_t0;
              if (elapsed >= lat_dwell) begin
                r.profile_write = 1'b1;
                r.profile_speed = speed_limit(cfg_ret);
                r.torque_limit = lat_torque[2];
                act_target = org_user;
                r.target_write = TW_HW;
                r.target_value = org_hw;
                seq_phase = PH_RETURN;
              end
            end
            PH_RETURN: begin
              if (within_tol(w.pos_hw, org_hw, ReturnTol)) begin
                seq_phase = PH_IDLE;
                dwell_t0 = '0;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (nxt >= 0) begin
      r.profile_write = 1'b1;
      r.profile_speed = lat_speed[nxt];
      r.torque_limit = lat_torque[nxt];
      act_target = lat_pos[nxt];
      r.target_write = TW_USER;
      r.target_value = act_target;
      seq_phase = phase_t'(nxt + 1);
    end
    r.sequence_state = seq_phase;
    due_results.push_back(r);
  endtask

  task automatic check_field(input string tag, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s: expected 0x%0h actual 0x%0h", $time, tag, want, got);
      mismatches++;
    end
  endtask

  task automatic check_command();
    mps_result_t want;
    mps_result_t got;
    got.start_accepted = start_accepted;
    got.target_write = target_write;
    got.target_value = target_value;
    got.profile_write = profile_write;
    got.profile_speed = profile_speed;
    got.torque_limit = torque_limit;
    got.sequence_state = sequence_state;
    if (due_results.size() == 0) begin
      $display("%0t unexpected word: expected none actual 0x%0h", $time, got);
      mismatches++;
    end else begin
      want = due_results.pop_front();
      check_field("start_accepted", want.start_accepted, got.start_accepted);
      check_field("target_write", want.target_write, got.target_write);
      check_field("target_value", want.target_value, got.target_value);
      check_field("profile_write", want.profile_write, got.profile_write);
      check_field("profile_speed", want.profile_speed, got.profile_speed);
      check_field("torque_limit", want.torque_limit, got.torque_limit);
      check_field("sequence_state", want.sequence_state, got.sequence_state);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_command();
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 13);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input cmd_t w);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= w.mode;
    pdo_ready <= w.pdo;
    run_enabled <= w.run;
    status_word <= w.status;
    actual_position <= w.pos;
    actual_position_hw <= w.pos_hw;
    now_ms <= w.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sequencer(w);
  endtask

  // hold the input and drain every outstanding command word
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_STEP1_POS:  cfg_pos[0] = data[31:0];
      REG_STEP2_POS:  cfg_pos[1] = data[31:0];
      REG_STEP3_POS:  cfg_pos[2] = data[31:0];
      REG_STEP1_ST:   cfg_st[0] = data;
      REG_STEP2_ST:   cfg_st[1] = data;
      REG_STEP3_ST:   cfg_st[2] = data;
      REG_DWELL:      cfg_dwell = data[31:0];
      REG_RETURN_SPD: cfg_ret = data[31:0];
      default: ;
    endcase
  endtask

  task automatic load_program(input prog_t p);
    settle();
    write_reg(REG_STEP1_POS, {16'h0, p.pos[0]});
    write_reg(REG_STEP2_POS, {16'h0, p.pos[1]});
    write_reg(REG_STEP3_POS, {16'h0, p.pos[2]});
    write_reg(REG_STEP1_ST, p.st[0]);
    write_reg(REG_STEP2_ST, p.st[1]);
    write_reg(REG_STEP3_ST, p.st[2]);
    write_reg(REG_DWELL, {16'h0, p.dwell});
    write_reg(REG_RETURN_SPD, {16'h0, p.ret});
    cfg_valid <= 1'b0;
  endtask

  function automatic cmd_t word_of(logic [1:0] m, logic p, logic r, logic [15:0] s,
                                   logic [31:0] x, logic [31:0] h, logic [31:0] t);
    cmd_t w;
    w.mode = m;
    w.pdo = p;
    w.run = r;
    w.status = s;
    w.pos = x;
    w.pos_hw = h;
    w.now = t;
    return w;
  endfunction

  function automatic logic [15:0] good_status();
    return (16'($urandom) & ~StatusMask) | StatusOpEn;
  endfunction

  function automatic logic [15:0] bad_status();
    logic [15:0] s;
    s = 16'($urandom);
    if ((s & StatusMask) == StatusOpEn) begin
      s = s ^ (StatusMask & ~StatusOpEn);
    end
    return s;
  endfunction

  function automatic logic [31:0] rand_speed();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_torque();
    case ($urandom_range(0, 9))
      0: return 16'h0;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'd100;
      4: return 16'd101;
      5: return -16'sd100;
      6: return -16'sd101;
      7: return 16'($urandom_range(0, 240)) - 16'd120;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic prog_t random_prog();
    prog_t p;
    int    i;
    for (i = 0; i < NumSteps; i++) begin
      case ($urandom_range(0, 5))
        0: p.pos[i] = 32'h8000_0000;
        1: p.pos[i] = 32'h7FFF_FFFF;
        default: p.pos[i] = $urandom;
      endcase
      p.st[i] = {rand_torque(), rand_speed()};
    end
    case ($urandom_range(0, 9))
      0: p.dwell = $urandom | 32'h8000_0000;
      1: p.dwell = 32'h7FFF_FFFF;
      2: p.dwell = 32'h0;
      default: p.dwell = $urandom_range(1, 40);
    endcase
    p.ret = rand_speed();
    return p;
  endfunction

  // mostly well-formed program traffic, steered by the model phase
  function automatic cmd_t next_word();
    cmd_t w;
    int   r;
    r = $urandom_range(0, 99);
    ms_now = ms_now + $urandom_range(0, 12);
    if ($urandom_range(0, 40) == 0) begin
      ms_now = $urandom;
    end
    w = word_of(MODE_TICK, 1'b1, 1'b1, good_status(), $urandom, $urandom, ms_now);
    if (r < 8) begin
      w.mode = 2'($urandom_range(0, 3));
      w.pdo = 1'($urandom);
      w.run = 1'($urandom);
      w.status = 16'($urandom);
      return w;
    end
    if (r < 11) begin
      w.mode = MODE_STOP;
      return w;
    end
    case (seq_phase)
      PH_IDLE: begin
        w.mode = MODE_START;
        if (r < 30) begin
          case ($urandom_range(0, 2))
            0: w.pdo = 1'b0;
            1: w.run = 1'b0;
            default: w.status = bad_status();
          endcase
        end
      end
      PH_STEP1, PH_STEP2, PH_STEP3: begin
        if (r < 18) begin
          w.mode = MODE_START;
        end else if (r < 24) begin
          w.pdo = 1'b0;
        end else if (r < 88) begin
          w.pos = 32'(longint'(act_target) + longint'($urandom_range(0, 260)) - 130);
        end
      end
      PH_DWELL: begin
        if (r < 18) begin
          w.pdo = 1'b0;
        end
      end
      PH_RETURN: begin
        if (r < 80) begin
          w.pos_hw = 32'(longint'(org_hw) + longint'($urandom_range(0, 16)) - 8);
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_reset_program();
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, StatusOpEn, 0, 0, 0));
    send_word(word_of(MODE_STOP, 1'b1, 1'b1, StatusOpEn, 0, 0, 0));
    send_word(word_of(ModeUnused, 1'b1, 1'b1, StatusOpEn, 0, 0, 0));
    send_word(word_of(MODE_START, 1'b0, 1'b1, StatusOpEn, 1234, -77, 0));
    send_word(word_of(MODE_START, 1'b1, 1'b0, StatusOpEn, 1234, -77, 0));
    send_word(word_of(MODE_START, 1'b1, 1'b1, 16'h0000, 1234, -77, 0));
    send_word(word_of(MODE_START, 1'b1, 1'b1, StatusOpEn, 1234, -77, 0));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, StatusOpEn, 0, 0, 0));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, StatusOpEn, -100, 0, 0));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, StatusOpEn, 100, 0, 500));
    send_word(word_of(MODE_TICK, 1'b0, 1'b1, StatusOpEn, 100, 0, 500));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, StatusOpEn, 100, 0, 500));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, StatusOpEn, 0, -71, 501));
    send_word(word_of(MODE_STOP, 1'b1, 1'b1, StatusOpEn, 4321, -71, 502));
  endtask

  task automatic test_extreme_program();
    prog_t p;
    p.pos[0] = 32'h8000_0000;
    p.pos[1] = 32'h7FFF_FFFF;
    p.pos[2] = 32'h0;
    p.st[0] = {16'h8000, 32'h8000_0000};
    p.st[1] = {16'h7FFF, 32'h0000_0000};
    p.st[2] = {16'hFF9B, 32'hFFFF_FFFB};
    p.dwell = 32'd20;
    p.ret = 32'h8000_0000;
    load_program(p);
    send_word(word_of(MODE_START, 1'b1, 1'b1, 16'hFFB7, 32'h7FFF_FFFF, 32'h8000_0000,
                      0));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, 16'hFFB7, 32'h8000_0065, 0, 0));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, 16'hFFB7, 32'h8000_0064, 0, 0));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, 16'hFFB7, 32'h7FFF_FF9B, 0, 0));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, 16'hFFB7, 100, 0, 32'hFFFF_FFF8));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, 16'hFFB7, 0, 0, 32'h0000_000B));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, 16'hFFB7, 0, 0, 32'h0000_000C));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, 16'hFFB7, 0, 32'h8000_0006, 13));
    send_word(word_of(ModeUnused, 1'b1, 1'b1, 16'hFFB7, 0, 32'h8000_0005, 14));
    send_word(word_of(MODE_TICK, 1'b1, 1'b1, 16'hFFB7, 0, 32'h8000_0005, 15));
  endtask

  task automatic test_random_programs();
    int ph;
    int k;
    for (ph = 0; ph < RandPhases; ph++) begin
      idle_on = (ph != RandPhases - 1) && ($urandom_range(0, 3) != 0);
      load_program(random_prog());
      for (k = 0; k < WordsPerPhase; k++) begin
        if ($urandom_range(0, 149) == 0) begin
          settle();
        end
        send_word(next_word());
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    test_reset_program();
    test_extreme_program();
    test_random_programs();
    settle();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mps_pkg.sv
hw/rtl/mps_cfg.sv
hw/rtl/mps_core.sv
hw/rtl/mps_obuf.sv
hw/rtl/motion_program_sequencer_unit.sv
hw/rtl/mps_checker.sv
tb/testbench.sv
